@@ rtl/sfp_pkg.sv @@
`timescale 1ns / 1ps

package sfp_pkg;

   localparam int CHANNEL_W = 4;
   localparam int WIDTH_W   = 16;
   localparam int BYTE_W    = 8;

   localparam logic [BYTE_W-1:0] HDR_FULL_0  = 8'hFF;
   localparam logic [BYTE_W-1:0] HDR_FULL_1  = 8'hEE;
   localparam logic [BYTE_W-1:0] HDR_COUNT_0 = 8'hFE;
   localparam logic [BYTE_W-1:0] HDR_COUNT_1 = 8'hEF;

   typedef enum logic [6:0] {
      PH_IGNORE  = 7'b0000001,
      PH_HDR_EE  = 7'b0000010,
      PH_HDR_EF  = 7'b0000100,
      PH_COUNT   = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_CK_A    = 7'b0100000,
      PH_CK_B    = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      EM_IDLE = 3'b001,
      EM_READ = 3'b010,
      EM_LOAD = 3'b100
   } emit_state_type;

endpackage

@@ rtl/servo_frame_parser_fletcher.sv @@
`timescale 1ns / 1ps
// Channel | Ports                                        | Direction
// req     | req_valid req_ready req_data_byte req_start_of_read | in
// rsp     | rsp_valid rsp_ready rsp_channel rsp_pulse_width rsp_last | out
//
// Bytes are taken while req_ready is high; widths go into a one-port-write, one-port-read
// memory of MAX_SERVOS entries as the low byte of each width arrives.
// A good checksum starts the readout: each result is a memory read, then a load
// of the output register; req_ready stays low until the last result is loaded.
// Reset is synchronous; the parser then ignores bytes until a start word.
// A stalled rsp_ready holds the readout in place; no result is dropped.

module servo_frame_parser_fletcher
   import sfp_pkg::*;
#(
   parameter int MAX_SERVOS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_data_byte,
   input  logic                 req_start_of_read,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHANNEL_W-1:0] rsp_channel,
   output logic [WIDTH_W-1:0]   rsp_pulse_width,
   output logic                 rsp_last
);

   localparam int CW = $clog2(MAX_SERVOS + 1);
   localparam int AW = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

   logic               accept;
   logic               busy;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [WIDTH_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [WIDTH_W-1:0] rd_data;
   logic               frame_ok;
   logic [CW-1:0]      frame_count;

   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   sfp_parser #(
      .MAX_SERVOS (MAX_SERVOS),
      .CW         (CW),
      .AW         (AW)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .start_of_read (req_start_of_read),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .frame_ok      (frame_ok),
      .frame_count   (frame_count)
   );

   sfp_store #(
      .DEPTH (MAX_SERVOS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfp_emit #(
      .CW (CW),
      .AW (AW)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .frame_ok        (frame_ok),
      .frame_count     (frame_count),
      .busy            (busy),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_channel     (rsp_channel),
      .rsp_pulse_width (rsp_pulse_width),
      .rsp_last        (rsp_last)
   );

endmodule

@@ rtl/sfp_store.sv @@
`timescale 1ns / 1ps

module sfp_store
   import sfp_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [WIDTH_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [WIDTH_W-1:0] rd_data
);

   logic [WIDTH_W-1:0] mem_ff [DEPTH];
   logic [WIDTH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sfp_parser.sv @@
`timescale 1ns / 1ps

module sfp_parser
   import sfp_pkg::*;
#(
   parameter int MAX_SERVOS = 8,
   parameter int CW         = 4,
   parameter int AW         = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic               start_of_read,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output logic [WIDTH_W-1:0] wr_data,
   output logic               frame_ok,
   output logic [CW-1:0]      frame_count
);

   localparam int IW = $clog2(2 * MAX_SERVOS + 1);

   phase_type         phase_ff, phase_in;
   logic [IW-1:0]     index_ff, index_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0] check_a_ff, check_a_in;
   logic [BYTE_W-1:0] high_ff, high_in;
   logic [BYTE_W-1:0] sum_a_next;
   logic [CW-1:0]     clamped;
   logic [IW:0]       index_next;
   logic [IW:0]       payload_len;

   assign sum_a_next  = sum_a_ff + data_byte;
   assign index_next  = {1'b0, index_ff} + (IW+1)'(1);
   assign payload_len = (IW+1)'({count_ff, 1'b0});
   assign clamped     = (data_byte > BYTE_W'(MAX_SERVOS)) ? CW'(MAX_SERVOS)
                                                          : CW'(data_byte);

   always_comb begin
      phase_in   = phase_ff;
      index_in   = index_ff;
      count_in   = count_ff;
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      check_a_in = check_a_ff;
      high_in    = high_ff;
      wr_en      = 1'b0;
      frame_ok   = 1'b0;
      if (accept) begin
         if (start_of_read) begin
            if (data_byte == HDR_FULL_0) begin
               phase_in = PH_HDR_EE;
            end else if (data_byte == HDR_COUNT_0) begin
               phase_in = PH_HDR_EF;
            end else begin
               phase_in = PH_IGNORE;
            end
         end else begin
            case (phase_ff)
               PH_HDR_EE: begin
                  if (data_byte == HDR_FULL_1) begin
                     count_in = CW'(MAX_SERVOS);
                     index_in = '0;
                     sum_a_in = '0;
                     sum_b_in = '0;
                     phase_in = PH_PAYLOAD;
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
               PH_HDR_EF: begin
                  phase_in = (data_byte == HDR_COUNT_1) ? PH_COUNT : PH_IGNORE;
               end
               PH_COUNT: begin
                  count_in = clamped;
                  index_in = '0;
                  sum_a_in = '0;
                  sum_b_in = '0;
                  phase_in = (clamped == '0) ? PH_IGNORE : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  // hold the high byte, write the whole width on the low byte
                  if (!index_ff[0]) begin
                     high_in = data_byte;
                  end else begin
                     wr_en = 1'b1;
                  end
                  sum_a_in = sum_a_next;
                  sum_b_in = sum_b_ff + sum_a_next;
                  index_in = index_next[IW-1:0];
                  if (index_next >= payload_len) begin
                     phase_in = PH_CK_A;
                  end
               end
               PH_CK_A: begin
                  check_a_in = data_byte;
                  phase_in   = PH_CK_B;
               end
               PH_CK_B: begin
                  frame_ok = (check_a_ff == sum_a_ff) && (data_byte == sum_b_ff);
                  phase_in = PH_IGNORE;
               end
               default: begin
                  phase_in = PH_IGNORE;
               end
            endcase
         end
      end
   end

   assign wr_addr     = index_ff[AW:1];
   assign wr_data     = {high_ff, data_byte};
   assign frame_count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IGNORE;
         index_ff   <= '0;
         count_ff   <= '0;
         sum_a_ff   <= '0;
         sum_b_ff   <= '0;
         check_a_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         count_ff   <= count_in;
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         check_a_ff <= check_a_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
   end

endmodule

@@ rtl/sfp_emit.sv @@
`timescale 1ns / 1ps

module sfp_emit
   import sfp_pkg::*;
#(
   parameter int CW = 4,
   parameter int AW = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_ok,
   input  logic [CW-1:0]        frame_count,
   output logic                 busy,
   output logic                 rd_en,
   output logic [AW-1:0]        rd_addr,
   input  logic [WIDTH_W-1:0]   rd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHANNEL_W-1:0] rsp_channel,
   output logic [WIDTH_W-1:0]   rsp_pulse_width,
   output logic                 rsp_last
);

   emit_state_type       state_ff, state_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 valid_ff, valid_in;
   logic [CHANNEL_W-1:0] channel_ff, channel_in;
   logic [WIDTH_W-1:0]   width_ff, width_in;
   logic                 last_ff, last_in;
   logic [CW:0]          k_plus;
   logic                 out_free;

   assign k_plus   = {1'b0, k_ff} + (CW+1)'(1);
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      k_in       = k_ff;
      count_in   = count_ff;
      valid_in   = valid_ff && !rsp_ready;
      channel_in = channel_ff;
      width_in   = width_ff;
      last_in    = last_ff;
      rd_en      = 1'b0;
      case (state_ff)
         EM_IDLE: begin
            if (frame_ok) begin
               count_in = frame_count;
               k_in     = '0;
               state_in = EM_READ;
            end
         end
         EM_READ: begin
            rd_en    = 1'b1;
            state_in = EM_LOAD;
         end
         EM_LOAD: begin
            // hold the read data until the output register frees up
            if (out_free) begin
               valid_in   = 1'b1;
               channel_in = CHANNEL_W'(k_plus);
               width_in   = rd_data;
               last_in    = (k_plus == {1'b0, count_ff});
               if (k_plus == {1'b0, count_ff}) begin
                  state_in = EM_IDLE;
               end else begin
                  k_in     = k_plus[CW-1:0];
                  state_in = EM_READ;
               end
            end
         end
         default: begin
            state_in = EM_IDLE;
         end
      endcase
   end

   assign busy            = (state_ff != EM_IDLE);
   assign rd_addr         = k_ff[AW-1:0];
   assign rsp_valid       = valid_ff;
   assign rsp_channel     = channel_ff;
   assign rsp_pulse_width = width_ff;
   assign rsp_last        = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         valid_ff <= 1'b0;
         k_ff     <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         k_ff     <= k_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      channel_ff <= channel_in;
      width_ff   <= width_in;
      last_ff    <= last_in;
   end

endmodule

@@ rtl/sfp_checker.sv @@
`timescale 1ns / 1ps

module sfp_checker
   import sfp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [CHANNEL_W-1:0] rsp_channel,
   input logic [WIDTH_W-1:0]   rsp_pulse_width,
   input logic                 rsp_last
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_width)
                                  && $stable(rsp_channel) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // channels count from one
   a_channel_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel != '0)
      else $error("rsp_channel is zero");

   // no byte taken while a frame is still being read out
   a_no_req_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("req_ready high during readout");

endmodule

bind servo_frame_parser_fletcher sfp_checker u_sfp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_channel     (rsp_channel),
   .rsp_pulse_width (rsp_pulse_width),
   .rsp_last        (rsp_last)
);
